@@ rtl/mppg_pkg.sv @@
// Shared types and constants for the phased PWM generator.
package mppg_pkg;

    localparam int OUT_GROUPS = 6;
    localparam int OUT_BITS   = 18;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_STOP = 3'd1,
        OP_INIT = 3'd2,
        OP_ZERO = 3'd3,
        OP_CONF = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_FREQ  = 3'd1,
        ST_BAD_DUTY  = 3'd2,
        ST_BAD_PHASE = 3'd3,
        ST_BAD_CHAN  = 3'd4,
        ST_BAD_GROUP = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] group;
        logic [4:0] channel;
        logic [9:0] frequency_hz;
        logic [9:0] duty_percent;
        logic [9:0] phase_degrees;
    } t_in_item;

    typedef struct packed {
        logic [17:0] bits_group_a;
        logic [17:0] bits_group_b;
        logic [17:0] bits_group_c;
        logic [17:0] bits_group_d;
        logic [17:0] bits_group_e;
        logic [17:0] bits_group_f;
        logic [2:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_DIV,
        S_WRITE,
        S_OUT
    } t_state;

    // Sweep operation applied to every channel.
    typedef enum logic [1:0] {
        SW_TICK,
        SW_RELOAD,
        SW_ZERO,
        SW_CLEAR
    } t_sweep_op;

    typedef struct packed {
        logic      sweep_start;
        t_sweep_op sweep_op;
        logic      div_start;
        logic      cfg_write;
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic div_done;
    } t_stat;

endpackage

@@ rtl/mppg_divider.sv @@
// Radix-2 restoring divider: one quotient bit per cycle.
module mppg_divider #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        n_quot  = {r_quot[NUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quot = r_quot;
endmodule

@@ rtl/mppg_datapath.sv @@
// Channel tables, sweep engine and configure arithmetic.
module mppg_datapath #(
    parameter int NUM_GROUPS         = 6,
    parameter int CHANNELS_PER_GROUP = 18,
    parameter int COUNT_WIDTH        = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mppg_pkg::t_cmd     i_cmd,
    input  mppg_pkg::t_in_item i_item,
    input  logic [15:0]        i_rate,
    output mppg_pkg::t_stat    o_stat,
    output logic [NUM_GROUPS*CHANNELS_PER_GROUP-1:0] o_levels
);
    localparam int NCH   = NUM_GROUPS * CHANNELS_PER_GROUP;
    localparam int IW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int NUM_W = 26;
    localparam int DEN_W = 18;
    localparam int GW    = $clog2(CHANNELS_PER_GROUP + 1) + 3;

    // Counter, period, threshold, phase tables: one entry per channel.
    logic [COUNT_WIDTH-1:0] m_cnt   [NCH];
    logic [COUNT_WIDTH-1:0] m_per   [NCH];
    logic [COUNT_WIDTH-1:0] m_on    [NCH];
    logic [COUNT_WIDTH-1:0] m_phase [NCH];
    logic [NCH-1:0]         r_level;

    // Sweep: read stage at r_idx, write-back stage at r_wr_idx.
    logic [IW-1:0]          r_idx, r_wr_idx;
    logic                   r_sweep, r_wr_v, r_done;
    mppg_pkg::t_sweep_op    r_op;
    logic [COUNT_WIDTH-1:0] r_rd_cnt, r_rd_per, r_rd_on, r_rd_ph;
    logic [COUNT_WIDTH:0]   w_next;
    logic                   w_wrap;
    logic [GW-1:0]          w_cidx;

    // Divider sequencing for period, threshold, phase.
    logic [1:0]             r_dsel;
    logic                   r_dgo;
    logic                   w_ddone;
    logic [NUM_W-1:0]       w_quot, w_num;
    logic [DEN_W-1:0]       w_den;
    logic [COUNT_WIDTH-1:0] r_res [3];
    logic                   r_div_done;
    logic [COUNT_WIDTH-1:0] w_sat;

    assign w_next = {1'b0, r_rd_cnt} + 1'b1;
    assign w_wrap = (w_next > {1'b0, r_rd_per});
    assign w_cidx = GW'(i_item.group) * GW'(CHANNELS_PER_GROUP) + GW'(i_item.channel);

    // Reset starts a clearing pass that loads every entry with its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= 1'b1;
            r_idx    <= '0;
            r_op     <= mppg_pkg::SW_CLEAR;
            r_wr_v   <= 1'b0;
            r_wr_idx <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_wr_v   <= r_sweep;
            r_wr_idx <= r_idx;
            if (i_cmd.sweep_start) begin
                r_sweep <= 1'b1;
                r_idx   <= '0;
                r_op    <= i_cmd.sweep_op;
            end else if (r_sweep) begin
                if (r_idx == IW'(NCH - 1)) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_wr_v && r_wr_idx == IW'(NCH - 1)) r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cnt <= m_cnt[r_idx];
        r_rd_per <= m_per[r_idx];
        r_rd_on  <= m_on[r_idx];
        r_rd_ph  <= m_phase[r_idx];
    end

    // A configure write never overlaps a sweep.
    always_ff @(posedge i_clk) begin
        if (r_wr_v) begin
            unique case (r_op)
                mppg_pkg::SW_TICK:
                    m_cnt[r_wr_idx] <= w_wrap ? '0 : w_next[COUNT_WIDTH-1:0];
                mppg_pkg::SW_RELOAD: m_cnt[r_wr_idx] <= r_rd_ph;
                mppg_pkg::SW_ZERO:   m_on[r_wr_idx]  <= r_rd_per;
                mppg_pkg::SW_CLEAR: begin
                    m_cnt[r_wr_idx]   <= '0;
                    m_per[r_wr_idx]   <= COUNT_WIDTH'(500);
                    m_on[r_wr_idx]    <= COUNT_WIDTH'(125);
                    m_phase[r_wr_idx] <= '0;
                end
            endcase
        end else if (i_cmd.cfg_write) begin
            m_per[w_cidx[IW-1:0]]   <= r_res[0];
            m_on[w_cidx[IW-1:0]]    <= r_res[1];
            m_phase[w_cidx[IW-1:0]] <= r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (r_wr_v) begin
            if (r_op != mppg_pkg::SW_TICK || w_wrap) r_level[r_wr_idx] <= 1'b0;
            else if (w_next > {1'b0, r_rd_on}) r_level[r_wr_idx] <= 1'b1;
        end
    end

    always_comb begin
        unique case (r_dsel)
            2'd0: begin
                w_num = NUM_W'({i_rate, 1'b0}) + NUM_W'(i_item.frequency_hz);
                w_den = DEN_W'({i_item.frequency_hz, 1'b0});
            end
            2'd1: begin
                w_num = NUM_W'({i_rate, 1'b0}) * NUM_W'(7'd100 - i_item.duty_percent[6:0])
                      + NUM_W'(i_item.frequency_hz) * NUM_W'(100);
                w_den = DEN_W'(i_item.frequency_hz) * DEN_W'(200);
            end
            default: begin
                w_num = NUM_W'({i_rate, 1'b0}) * NUM_W'(i_item.phase_degrees)
                      + NUM_W'(i_item.frequency_hz) * NUM_W'(360);
                w_den = DEN_W'(i_item.frequency_hz) * DEN_W'(720);
            end
        endcase
    end

    assign w_sat = (w_quot > NUM_W'({COUNT_WIDTH{1'b1}})) ? '1 : COUNT_WIDTH'(w_quot);

    mppg_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dgo),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsel     <= '0;
            r_dgo      <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_dgo      <= 1'b0;
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_dsel <= 2'd0;
                r_dgo  <= 1'b1;
            end else if (w_ddone) begin
                r_res[r_dsel] <= w_sat;
                if (r_dsel == 2'd2) begin
                    r_div_done <= 1'b1;
                end else begin
                    r_dsel <= r_dsel + 1'b1;
                    r_dgo  <= 1'b1;
                end
            end
        end
    end

    assign o_stat.sweep_done = r_done;
    assign o_stat.div_done   = r_div_done;
    assign o_levels          = r_level;
endmodule

@@ rtl/mppg_ctrl.sv @@
// Control state machine: decode item, sequence sweeps and configure.
module mppg_ctrl #(
    parameter int NUM_GROUPS         = 6,
    parameter int CHANNELS_PER_GROUP = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mppg_pkg::t_in_item i_in_data,
    input  logic               i_out_busy,
    input  mppg_pkg::t_stat    i_stat,
    output logic               o_in_stall,
    output mppg_pkg::t_cmd     o_cmd,
    output mppg_pkg::t_in_item o_item,
    output logic               o_res_load,
    output logic [2:0]         o_status
);
    mppg_pkg::t_state   r_state, n_state;
    mppg_pkg::t_in_item r_item;
    logic               r_run, n_run;
    logic [2:0]         r_status, n_status;
    logic               w_acc;
    logic [2:0]         w_chk;

    assign o_in_stall = (r_state != mppg_pkg::S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_item     = r_item;
    assign o_status   = r_status;

    always_comb begin
        priority if (i_in_data.frequency_hz == '0 || i_in_data.frequency_hz > 10'd200)
            w_chk = mppg_pkg::ST_BAD_FREQ;
        else if (i_in_data.duty_percent > 10'd100)
            w_chk = mppg_pkg::ST_BAD_DUTY;
        else if (i_in_data.phase_degrees > 10'd360)
            w_chk = mppg_pkg::ST_BAD_PHASE;
        else if (32'(i_in_data.channel) >= CHANNELS_PER_GROUP)
            w_chk = mppg_pkg::ST_BAD_CHAN;
        else if (32'(i_in_data.group) >= NUM_GROUPS || i_in_data.group >= 3'd6)
            w_chk = mppg_pkg::ST_BAD_GROUP;
        else
            w_chk = mppg_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mppg_pkg::S_CLEAR;
            r_run    <= 1'b0;
            r_status <= '0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_item <= i_in_data;
    end

    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        n_status   = r_status;
        o_cmd      = '0;
        o_res_load = 1'b0;
        unique case (r_state)
            // Hold input off until the tables hold their reset values.
            mppg_pkg::S_CLEAR: if (i_stat.sweep_done) n_state = mppg_pkg::S_IDLE;
            mppg_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_status = mppg_pkg::ST_OK;
                    n_state  = mppg_pkg::S_OUT;
                    unique case (i_in_data.opcode)
                        mppg_pkg::OP_TICK: begin
                            if (r_run) begin
                                o_cmd.sweep_start = 1'b1;
                                o_cmd.sweep_op    = mppg_pkg::SW_TICK;
                                n_state           = mppg_pkg::S_SWEEP;
                            end
                        end
                        mppg_pkg::OP_STOP, mppg_pkg::OP_INIT: begin
                            n_run             = (i_in_data.opcode == mppg_pkg::OP_INIT);
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.sweep_op    = mppg_pkg::SW_RELOAD;
                            n_state           = mppg_pkg::S_SWEEP;
                        end
                        mppg_pkg::OP_ZERO: begin
                            n_run             = 1'b1;
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.sweep_op    = mppg_pkg::SW_ZERO;
                            n_state           = mppg_pkg::S_SWEEP;
                        end
                        mppg_pkg::OP_CONF: begin
                            n_status = w_chk;
                            if (w_chk == mppg_pkg::ST_OK) begin
                                o_cmd.div_start = 1'b1;
                                n_state         = mppg_pkg::S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mppg_pkg::S_SWEEP: if (i_stat.sweep_done) n_state = mppg_pkg::S_OUT;
            mppg_pkg::S_DIV:   if (i_stat.div_done) n_state = mppg_pkg::S_WRITE;
            mppg_pkg::S_WRITE: begin
                o_cmd.cfg_write = 1'b1;
                n_state         = mppg_pkg::S_OUT;
            end
            mppg_pkg::S_OUT: begin
                // Wait for the output register to free up, then load it.
                if (!i_out_busy) begin
                    o_res_load = 1'b1;
                    n_state    = mppg_pkg::S_IDLE;
                end
            end
            default: n_state = mppg_pkg::S_IDLE;
        endcase
    end
endmodule

@@ rtl/multichannel_phased_pwm_generator_unit.sv @@
// Top level of the multichannel phased PWM generator.
// Accepts one item at a time. After reset the block stalls its input while
// one pass loads every channel table entry with its reset value. A running
// tick, stop, init or zero item sweeps all NUM_GROUPS*CHANNELS_PER_GROUP
// channels one per cycle through a read stage and a write-back stage; a
// configure item runs three 26-step divisions on a shared serial divider;
// an invalid configure, a tick while stopped or an unknown opcode goes
// straight to the output. The result sits in an output register, and the
// block takes the next item while it waits; a finished item waits only while
// the previous result is still held.
module multichannel_phased_pwm_generator_unit #(
    parameter int NUM_GROUPS         = 6,
    parameter int CHANNELS_PER_GROUP = 18,
    parameter int COUNT_WIDTH        = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mppg_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mppg_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    localparam int NCH = NUM_GROUPS * CHANNELS_PER_GROUP;

    logic [15:0]        r_rate;
    mppg_pkg::t_cmd     w_cmd;
    mppg_pkg::t_stat    w_stat;
    mppg_pkg::t_in_item w_item;
    logic               w_load;
    logic [2:0]         w_status;
    logic [NCH-1:0]     w_levels;
    logic [mppg_pkg::OUT_BITS-1:0] w_bits [mppg_pkg::OUT_GROUPS];
    logic               r_out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rate <= 16'd49800;
        else if (i_cfg_valid) r_rate <= i_cfg_data;
    end

    mppg_ctrl #(
        .NUM_GROUPS(NUM_GROUPS), .CHANNELS_PER_GROUP(CHANNELS_PER_GROUP)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data),
        .i_out_busy(r_out_valid && i_out_stall),
        .i_stat(w_stat), .o_in_stall(o_in_stall), .o_cmd(w_cmd),
        .o_item(w_item), .o_res_load(w_load), .o_status(w_status)
    );

    mppg_datapath #(
        .NUM_GROUPS(NUM_GROUPS), .CHANNELS_PER_GROUP(CHANNELS_PER_GROUP),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(w_item),
        .i_rate(r_rate), .o_stat(w_stat), .o_levels(w_levels)
    );

    always_comb begin
        for (int g = 0; g < mppg_pkg::OUT_GROUPS; g++) begin
            w_bits[g] = '0;
            for (int c = 0; c < mppg_pkg::OUT_BITS; c++) begin
                if (g < NUM_GROUPS && c < CHANNELS_PER_GROUP)
                    w_bits[g][c] = w_levels[g*CHANNELS_PER_GROUP + c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_data.bits_group_a <= w_bits[0];
            o_out_data.bits_group_b <= w_bits[1];
            o_out_data.bits_group_c <= w_bits[2];
            o_out_data.bits_group_d <= w_bits[3];
            o_out_data.bits_group_e <= w_bits[4];
            o_out_data.bits_group_f <= w_bits[5];
            o_out_data.status       <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a held result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sweep_start || w_cmd.div_start) |=> o_in_stall)
        else $error("item accepted during work");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= 3'd5))
        else $error("status code out of range");
endmodule
